### design/fbpa_pkg.sv
// Shared types, codes and defaults of the fixed block pool allocator.
package fbpa_pkg;

  localparam int unsigned MaxSlotsDef = 512;

  // Register indexes of the configuration port
  localparam logic [2:0] RegPoolEnabled   = 3'd0;
  localparam logic [2:0] RegSlotCapacity  = 3'd1;
  localparam logic [2:0] RegSlotStride    = 3'd2;
  localparam logic [2:0] RegPoolBase      = 3'd3;
  localparam logic [2:0] RegHeaderBytes   = 3'd4;
  localparam logic [2:0] RegInitialBlocks = 3'd5;

  typedef enum logic [2:0] {
    StatOk         = 3'd0,
    StatDisabled   = 3'd1,
    StatTooLarge   = 3'd2,
    StatEmpty      = 3'd3,
    StatOutOfRange = 3'd4,
    StatNotInUse   = 3'd5
  } status_e;

  typedef struct packed {
    logic        mode;
    logic [15:0] request_size;
    logic [31:0] release_address;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] granted_address;
    logic [8:0]  slot_number;
    logic [9:0]  slots_in_use;
    logic [31:0] miss_total;
    logic [31:0] alloc_total;
    logic [31:0] release_total;
  } rsp_t;

endpackage

### design/fixed_block_pool_allocator_top.sv
// Fixed block pool allocator: free-index stack and in-use marks in synchronous memories.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------
//  in      | input     | in_valid_i / in_ready_o  | in_data_i  (req_t)
//  out     | output    | out_valid_o / out_ready_i| out_data_o (rsp_t)
//  cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// Refused requests are answered from the check state; allocations go through
// the stack read and then the index*stride multiply; frees go through the one
// bit per cycle divider and the in-use mark read. One request is worked at a time.
// After reset and after every initial_blocks write a clearing pass over all
// MAX_SLOTS entries wipes the in-use marks; no request beat is taken meanwhile.
// A stalled result sits in the output register while the next request runs.
module fixed_block_pool_allocator_top
  import fbpa_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = MaxSlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  req_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rsp_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned SW = $clog2(MAX_SLOTS);
  localparam int unsigned CW = $clog2(MAX_SLOTS + 1);

  typedef enum logic [8:0] {
    S_CLR  = 9'b000000001,
    S_IDLE = 9'b000000010,
    S_CHK  = 9'b000000100,
    S_POP  = 9'b000001000,
    S_MUL  = 9'b000010000,
    S_GNT  = 9'b000100000,
    S_DIV  = 9'b001000000,
    S_MRD  = 9'b010000000,
    S_MCHK = 9'b100000000
  } state_e;

  state_e state_q;
  logic   done_q;

  // configuration registers
  logic        en_q;
  logic [15:0] cap_q;
  logic [16:0] stride_q;
  logic [31:0] base_q;
  logic [7:0]  hdr_q;

  // pool state
  logic [CW-1:0] fc_q, use_q, lo_q;
  logic [31:0]   miss_q, alloc_q, rel_q;
  logic [SW-1:0] clr_q, slot_q;
  req_t          req_q;
  logic [SW+16:0] prod_q;
  logic [2:0]    res_stat_q;
  logic [31:0]   res_gnt_q;
  logic          out_valid_q;
  rsp_t          out_q;

  // memories
  logic [SW-1:0] stk_mem [MAX_SLOTS];
  logic          mark_mem [MAX_SLOTS];
  logic [SW-1:0] stk_rd_q;
  logic          stk_hit_q;
  logic          mark_rd_q;
  logic          stk_we, mark_we, mark_wd;
  logic [SW-1:0] stk_wa, stk_ra, mark_wa;
  logic [CW-1:0] fc_dec, n_load;

  // divider
  logic          div_start, div_done;
  logic [SW-1:0] div_quot;
  logic [33:0]   pool_end;
  logic          in_range;
  logic [31:0]   offset;

  assign fc_dec   = CW'(fc_q - 1'b1);
  assign stk_ra   = fc_dec[SW-1:0];
  assign pool_end = {2'b00, base_q} + 34'(34'(stride_q) * 34'(MAX_SLOTS));
  assign in_range = (stride_q != '0) && (req_q.release_address >= base_q) &&
                    ({2'b00, req_q.release_address} < pool_end);
  assign offset   = req_q.release_address - base_q;
  assign n_load   = ({22'b0, cfg_data_i[9:0]} > 32'(MAX_SLOTS)) ?
                    CW'(MAX_SLOTS) : CW'(cfg_data_i[9:0]);
  assign div_start = (state_q == S_CHK) && en_q && req_q.mode && in_range;

  // memory write controls
  always_comb begin
    stk_we  = 1'b0;
    stk_wa  = fc_q[SW-1:0];
    mark_we = 1'b0;
    mark_wa = slot_q;
    mark_wd = 1'b0;
    unique case (state_q)
      S_CLR: begin
        mark_we = 1'b1;
        mark_wa = clr_q;
      end
      S_MUL: begin
        mark_we = 1'b1;
        mark_wd = 1'b1;
      end
      S_MCHK: begin
        mark_we = mark_rd_q;
        stk_we  = mark_rd_q && (fc_q < CW'(MAX_SLOTS));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_wa] <= slot_q;
    stk_rd_q  <= stk_mem[stk_ra];
    stk_hit_q <= (fc_dec >= lo_q);
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    mark_rd_q <= mark_mem[slot_q];
  end

  fbpa_div #(.QW(SW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (offset),
    .divisor_i  (stride_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // control, counters and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      done_q      <= 1'b0;
      clr_q       <= '0;
      en_q        <= 1'b0;
      cap_q       <= 16'd8192;
      stride_q    <= 17'd8256;
      base_q      <= '0;
      hdr_q       <= 8'd32;
      fc_q        <= (MAX_SLOTS < 64) ? CW'(MAX_SLOTS) : CW'(64);
      lo_q        <= CW'(MAX_SLOTS);
      use_q       <= '0;
      miss_q      <= '0;
      alloc_q     <= '0;
      rel_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i) out_valid_q <= 1'b0;
      // finished result moves to the output register once it is free
      if (done_q && (!out_valid_q || out_ready_i)) begin
        done_q      <= 1'b0;
        out_valid_q <= 1'b1;
        state_q     <= S_IDLE;
      end
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == SW'(MAX_SLOTS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i && !done_q) state_q <= S_CHK;
        end
        S_CHK: begin
          if (!en_q) begin
            done_q <= 1'b1;
            state_q <= S_IDLE;
          end else if (!req_q.mode) begin
            if (req_q.request_size > cap_q) begin
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end else if (fc_q == '0) begin
              if (miss_q != '1) miss_q <= miss_q + 1'b1;
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              state_q <= S_POP;
            end
          end else if (!in_range) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_POP: begin
          fc_q    <= fc_dec;
          state_q <= S_MUL;
        end
        S_MUL: state_q <= S_GNT;
        S_GNT: begin
          if (use_q < CW'(MAX_SLOTS)) use_q <= use_q + 1'b1;
          if (alloc_q != '1) alloc_q <= alloc_q + 1'b1;
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        S_DIV: begin
          if (div_done) state_q <= S_MRD;
        end
        S_MRD: state_q <= S_MCHK;
        S_MCHK: begin
          if (mark_rd_q) begin
            if (fc_q < CW'(MAX_SLOTS)) begin
              fc_q <= fc_q + 1'b1;
              if (fc_q < lo_q) lo_q <= fc_q;
            end
            if (use_q != '0) use_q <= use_q - 1'b1;
            if (rel_q != '1) rel_q <= rel_q + 1'b1;
          end
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      // register writes; the stack reload restarts the mark sweep
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegPoolEnabled:  en_q     <= cfg_data_i[0];
          RegSlotCapacity: cap_q    <= cfg_data_i[15:0];
          RegSlotStride:   stride_q <= cfg_data_i[16:0];
          RegPoolBase:     base_q   <= cfg_data_i;
          RegHeaderBytes:  hdr_q    <= cfg_data_i[7:0];
          RegInitialBlocks: begin
            fc_q    <= n_load;
            lo_q    <= CW'(MAX_SLOTS);
            use_q   <= '0;
            miss_q  <= '0;
            alloc_q <= '0;
            rel_q   <= '0;
            clr_q   <= '0;
            state_q <= S_CLR;
          end
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q      <= in_data_i;
      res_stat_q <= StatOk;
      res_gnt_q  <= '0;
      slot_q     <= '0;
    end
    if (state_q == S_CHK) begin
      if (!en_q) res_stat_q <= StatDisabled;
      else if (!req_q.mode) begin
        if (req_q.request_size > cap_q) res_stat_q <= StatTooLarge;
        else if (fc_q == '0)            res_stat_q <= StatEmpty;
      end else if (!in_range)           res_stat_q <= StatOutOfRange;
    end
    // unwritten stack entries below the low-water mark hold their own index
    if (state_q == S_POP) slot_q <= stk_hit_q ? stk_rd_q : stk_ra;
    if (state_q == S_MUL) prod_q <= (SW + 17)'(slot_q) * (SW + 17)'(stride_q);
    if (state_q == S_GNT) res_gnt_q <= base_q + 32'(prod_q) + 32'(hdr_q);
    if (state_q == S_DIV && div_done) slot_q <= div_quot;
    if (state_q == S_MCHK && !mark_rd_q) begin
      res_stat_q <= StatNotInUse;
      slot_q     <= '0;
    end
    if (done_q && (!out_valid_q || out_ready_i)) begin
      out_q.status          <= res_stat_q;
      out_q.granted_address <= res_gnt_q;
      out_q.slot_number     <= 9'(slot_q);
      out_q.slots_in_use    <= 10'(use_q);
      out_q.miss_total      <= miss_q;
      out_q.alloc_total     <= alloc_q;
      out_q.release_total   <= rel_q;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE) && !done_q;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_fc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= CW'(MAX_SLOTS)) else $error("free count above pool size");
  a_use_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    use_q <= CW'(MAX_SLOTS)) else $error("use count above pool size");
  a_accept_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !cfg_valid_i) |=> (state_q == S_CHK))
    else $error("accepted request not checked");
`endif

endmodule

### design/fbpa_div.sv
// Restoring divider that maps a pool offset to a slot index, one quotient bit per cycle.
module fbpa_div
  import fbpa_pkg::*;
#(
  parameter int unsigned QW = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [31:0]   dividend_i,
  input  logic [16:0]   divisor_i,
  output logic          done_o,
  output logic [QW-1:0] quot_o
);

  localparam int unsigned DW = 17 + QW;
  localparam int unsigned NW = $clog2(QW + 1);

  logic [32:0]   rem_q;
  logic [DW-1:0] dsr_q;
  logic [QW-1:0] quot_q;
  logic [NW-1:0] cnt_q;
  logic          done_q;
  logic          fits;
  logic [32:0]   dsr_ext;

  // trial subtract of the shifted divisor
  always_comb begin
    if (DW > 33) begin
      dsr_ext = 33'(dsr_q);
      fits    = (dsr_q <= DW'(rem_q));
    end else begin
      dsr_ext = 33'(dsr_q);
      fits    = (rem_q >= dsr_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= NW'(QW);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == NW'(1));
      end
    end
  end

  // datapath: divisor starts aligned to the top quotient bit
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, dividend_i};
      dsr_q  <= DW'(divisor_i) << (QW - 1);
      quot_q <= '0;
    end else if (cnt_q != '0) begin
      if (fits) rem_q <= rem_q - dsr_ext;
      quot_q <= {quot_q[QW-2:0], fits};
      dsr_q  <= dsr_q >> 1;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### bench/testbench.sv
// Self-checking bench for the fixed block pool allocator: random and directed requests.
`timescale 1ns / 1ps

module testbench;
  import fbpa_pkg::*;

  localparam int unsigned SlotCount = MaxSlotsDef;
  localparam longint unsigned CycleLimit = 3000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  req_t        in_data;
  logic        out_valid;
  logic        out_ready;
  rsp_t        out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  fixed_block_pool_allocator_top i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  // Pool model state
  logic        pool_on;
  logic [15:0] capacity;
  logic [16:0] stride;
  logic [31:0] base_addr;
  logic [7:0]  header_len;
  logic [9:0]  init_count;
  logic [8:0]  free_idx [SlotCount];
  int unsigned free_depth;
  bit          busy_mark [SlotCount];
  int unsigned busy_count;
  logic [31:0] misses;
  logic [31:0] grants;
  logic [31:0] releases;

  rsp_t        pending_rsp[$];
  int unsigned error_count;
  int unsigned beat_count;
  int unsigned rsp_count;
  longint unsigned cycle_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_off;
  int unsigned hold_cycles;
  bit          pressure_seen;

  // Clock and cycle limit
  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t timeout after %0d cycles", $time, cycle_count);
      $display("** fixed_block_pool_allocator_top: FAILED **");
      $finish;
    end
  end

  function automatic logic [31:0] sat_step(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic void refill_pool();
    int unsigned n;
    n = (init_count > SlotCount) ? SlotCount : init_count;
    for (int i = 0; i < SlotCount; i++) begin
      free_idx[i] = (i < n) ? i[8:0] : 9'd0;
      busy_mark[i] = 1'b0;
    end
    free_depth = n;
    busy_count = 0;
    misses = '0;
    grants = '0;
    releases = '0;
  endfunction

  function automatic void model_reset();
    pool_on = 1'b0;
    capacity = 16'd8192;
    stride = 17'd8256;
    base_addr = '0;
    header_len = 8'd32;
    init_count = 10'd64;
    refill_pool();
  endfunction

  function automatic void model_write(logic [2:0] idx, logic [31:0] val);
    case (idx)
      RegPoolEnabled:   pool_on = val[0];
      RegSlotCapacity:  capacity = val[15:0];
      RegSlotStride:    stride = val[16:0];
      RegPoolBase:      base_addr = val;
      RegHeaderBytes:   header_len = val[7:0];
      RegInitialBlocks: begin
        init_count = val[9:0];
        refill_pool();
      end
      default: ;
    endcase
  endfunction

  // Predict the response to one request and update the pool model
  function automatic rsp_t pool_predict(req_t rq);
    rsp_t r;
    logic [63:0] span_end;
    logic [31:0] idx;
    r = '0;
    if (!pool_on) begin
      r.status = StatDisabled;
    end else if (rq.mode == 1'b0) begin
      if (rq.request_size > capacity) begin
        r.status = StatTooLarge;
      end else if (free_depth == 0) begin
        r.status = StatEmpty;
        misses = sat_step(misses);
      end else begin
        free_depth--;
        r.slot_number = free_idx[free_depth];
        busy_mark[r.slot_number] = 1'b1;
        r.granted_address = base_addr + 32'(r.slot_number) * 32'(stride)
                            + 32'(header_len);
        if (busy_count < SlotCount) busy_count++;
        grants = sat_step(grants);
        r.status = StatOk;
      end
    end else begin
      span_end = 64'(base_addr) + 64'(SlotCount) * 64'(stride);
      if (stride == 0 || rq.release_address < base_addr
          || 64'(rq.release_address) >= span_end) begin
        r.status = StatOutOfRange;
      end else begin
        idx = (rq.release_address - base_addr) / 32'(stride);
        if (idx >= SlotCount || !busy_mark[idx]) begin
          r.status = StatNotInUse;
        end else begin
          busy_mark[idx] = 1'b0;
          if (free_depth < SlotCount) begin
            free_idx[free_depth] = idx[8:0];
            free_depth++;
          end
          if (busy_count > 0) busy_count--;
          releases = sat_step(releases);
          r.slot_number = idx[8:0];
          r.status = StatOk;
        end
      end
    end
    r.slots_in_use = busy_count[9:0];
    r.miss_total = misses;
    r.alloc_total = grants;
    r.release_total = releases;
    return r;
  endfunction

  // Send one request beat; prediction is made when accepted.
  // Valid stays up after the beat; the next caller lowers it or offers a new beat.
  task automatic send_request(req_t rq);
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= rq;
    do @(posedge clk); while (!in_ready);
    pending_rsp.insert(pending_rsp.size(), pool_predict(rq));
    beat_count++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    in_valid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    model_write(idx, val);
  endtask

  // Wait until every expected response is back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Receiver stalls and the response check
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        rsp_t exp_r;
        rsp_count++;
        if (pending_rsp.size() == 0) begin
          $display("%0t unexpected response %p", $time, out_data);
          error_count++;
        end else begin
          exp_r = pending_rsp.pop_front();
          if (out_data !== exp_r) begin
            $display("%0t mismatch: expected %p actual %p", $time, exp_r, out_data);
            error_count++;
          end
        end
      end
      if (hold_off) begin
        out_ready <= 1'b0;
        hold_cycles <= hold_cycles + 1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic req_t alloc_req(logic [15:0] sz);
    req_t rq;
    rq = '0;
    rq.request_size = sz;
    rq.release_address = $urandom;
    return rq;
  endfunction

  function automatic req_t free_req(logic [31:0] a);
    req_t rq;
    rq.mode = 1'b1;
    rq.request_size = 16'($urandom);
    rq.release_address = a;
    return rq;
  endfunction

  // Address of a data area inside slot s, at a random offset
  function automatic logic [31:0] slot_addr(int unsigned s);
    return base_addr + 32'(s) * 32'(stride) + 32'($urandom_range(stride - 1));
  endfunction

  task automatic run_directed();
    write_reg(RegInitialBlocks, 32'd3);
    send_request(alloc_req(16'd1));                 // disabled
    send_request(free_req(32'd100));                // disabled
    drain();
    write_reg(RegPoolEnabled, 32'd1);
    write_reg(RegSlotCapacity, 32'd65535);
    write_reg(RegSlotStride, 32'd131071);
    write_reg(RegPoolBase, 32'hFFFF_0000);
    write_reg(RegHeaderBytes, 32'd255);
    send_request(alloc_req(16'hFFFF));              // address wrap
    send_request(alloc_req(16'd0));
    send_request(alloc_req(16'd0));
    send_request(alloc_req(16'd0));                 // empty
    send_request(free_req(32'hFFFE_FFFF));          // below base
    send_request(free_req(32'hFFFF_FFFF));          // slot 0, rounded down
    send_request(free_req(32'hFFFF_FFFF));          // not in use
    drain();
    write_reg(RegSlotStride, 32'd0);                // zero stride
    send_request(free_req(32'hFFFF_0000));
    drain();
    write_reg(RegSlotStride, 32'd16);
    write_reg(RegPoolBase, 32'd0);
    write_reg(RegSlotCapacity, 32'd1);
    send_request(alloc_req(16'd2));                 // too large
    send_request(free_req(32'd8192));               // past the end
    send_request(free_req(32'd8191));               // last slot, not in use
    drain();
    write_reg(RegInitialBlocks, 32'd1023);          // clipped to slot count
    send_request(alloc_req(16'd1));
    send_request(free_req(32'd511 * 16 + 15));
    drain();
    write_reg(RegInitialBlocks, 32'd0);             // empty stack
    send_request(alloc_req(16'd0));
    drain();
    write_reg(3'd6, 32'hFFFF_FFFF);                 // unknown register
    write_reg(3'd7, 32'd0);
    send_request(alloc_req(16'd0));
    drain();
  endtask

  task automatic setup_pool(int unsigned n);
    write_reg(RegPoolEnabled, 32'd1);
    write_reg(RegSlotCapacity, $urandom_range(65535, 1));
    write_reg(RegSlotStride, ($urandom_range(3) == 0) ? $urandom_range(131071, 16)
                                                      : $urandom_range(300, 16));
    write_reg(RegPoolBase, $urandom);
    write_reg(RegHeaderBytes, $urandom_range(255));
    write_reg(RegInitialBlocks, n);
  endtask

  // Mostly allocate / free of live slots, some noise
  task automatic run_random(int unsigned count);
    int unsigned live[$];
    int unsigned k;
    int unsigned pick;
    logic [31:0] a;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_request(alloc_req(($urandom_range(9) == 0) ? 16'($urandom)
                               : 16'($urandom_range(capacity))));
        if (pending_rsp[$].status == StatOk)
          live.insert(live.size(), 32'(pending_rsp[$].slot_number));
      end else if (pick < 85 && live.size() != 0) begin
        k = $urandom_range(live.size() - 1);
        a = slot_addr(live[k]);
        live.delete(k);
        send_request(free_req(a));
      end else if (pick < 95) begin
        send_request(free_req(slot_addr($urandom_range(SlotCount - 1))));
      end else begin
        send_request(free_req($urandom));
      end
    end
  endtask

  task automatic run_idle_phases();
    int pct[4][2] = '{'{0, 0}, '{76, 0}, '{0, 76}, '{26, 26}};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = pct[p][0];
      recv_stall_pct = pct[p][1];
      setup_pool((p == 0) ? 1 : $urandom_range(40, 2));
      run_random(360);
      drain();
    end
    setup_pool(SlotCount);
    run_random(120);
    drain();
    write_reg(RegPoolEnabled, 32'd0);
    run_random(20);
    drain();
  endtask

  // Long receiver hold-off while requests keep coming
  task automatic run_backpressure();
    send_idle_pct = 0;
    setup_pool(8);
    hold_off = 1'b1;
    fork
      run_random(40);
      begin
        while (hold_cycles < 400) @(posedge clk);
        pressure_seen = !in_ready;
        hold_off = 1'b0;
      end
    join
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    error_count = 0;
    beat_count = 0;
    rsp_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b0;
    hold_cycles = 0;
    pressure_seen = 1'b0;
    model_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_idle_phases();
    run_backpressure();
    drain();
    $display("Ran %0d requests, %0d responses checked, across idle/stall phases", beat_count,
             rsp_count);
    $display("and pool sizes 0..%0d; input stalled under hold-off: %0d", SlotCount,
             pressure_seen);
    if (error_count == 0) begin
      $display("** fixed_block_pool_allocator_top: PASSED **");
    end else begin
      $display("** fixed_block_pool_allocator_top: FAILED **");
    end
    $finish;
  end

endmodule
